FILE: src/mhe_pkg.sv
`default_nettype none
package mhe_pkg;

  localparam int CMD_W   = 4;
  localparam int VALUE_W = 64;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CMD_W-1:0] CMD_NIL    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_FALSE  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_TRUE   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SINT   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_UINT   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DOUBLE = 4'd5;
  localparam logic [CMD_W-1:0] CMD_STRING = 4'd6;
  localparam logic [CMD_W-1:0] CMD_BUFFER = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SYMBOL = 4'd8;
  localparam logic [CMD_W-1:0] CMD_ARRAY  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_MAP    = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_STRING_AS_BIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_AS_BIN = 1'd1;

  localparam logic [BYTE_W-1:0] TAG_NIL      = 8'hC0;
  localparam logic [BYTE_W-1:0] TAG_FALSE    = 8'hC2;
  localparam logic [BYTE_W-1:0] TAG_TRUE     = 8'hC3;
  localparam logic [BYTE_W-1:0] TAG_BIN8     = 8'hC4;
  localparam logic [BYTE_W-1:0] TAG_DOUBLE   = 8'hCB;
  localparam logic [BYTE_W-1:0] TAG_UINT8    = 8'hCC;
  localparam logic [BYTE_W-1:0] TAG_UINT16   = 8'hCD;
  localparam logic [BYTE_W-1:0] TAG_UINT32   = 8'hCE;
  localparam logic [BYTE_W-1:0] TAG_UINT64   = 8'hCF;
  localparam logic [BYTE_W-1:0] TAG_INT8     = 8'hD0;
  localparam logic [BYTE_W-1:0] TAG_INT16    = 8'hD1;
  localparam logic [BYTE_W-1:0] TAG_INT32    = 8'hD2;
  localparam logic [BYTE_W-1:0] TAG_INT64    = 8'hD3;
  localparam logic [BYTE_W-1:0] TAG_STR8     = 8'hD9;
  localparam logic [BYTE_W-1:0] TAG_FIXSTR   = 8'hA0;
  localparam logic [BYTE_W-1:0] TAG_FIXARRAY = 8'h90;
  localparam logic [BYTE_W-1:0] TAG_ARRAY16  = 8'hDC;
  localparam logic [BYTE_W-1:0] TAG_FIXMAP   = 8'h80;
  localparam logic [BYTE_W-1:0] TAG_MAP16    = 8'hDE;

  // One classified token: the tag byte and the payload bytes that follow it,
  // with the first payload byte in the top byte of data.
  typedef struct packed {
    logic [BYTE_W-1:0]  tag;
    logic [VALUE_W-1:0] data;
    logic [CNT_W-1:0]   nbytes;
  } job_t;

endpackage
`default_nettype wire

FILE: src/mhe_if.sv
`default_nettype none
interface mhe_tok_if import mhe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink (input valid, cmd, value, output ready);
endinterface

interface mhe_byte_if import mhe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

FILE: src/mhe_front.sv
`default_nettype none
module mhe_front import mhe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mhe_tok_if.sink                    tok,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  full,
  output logic                       push,
  output job_t                       job
);

  logic string_as_bin;
  logic buffer_as_bin;
  logic as_bin;
  logic [VALUE_W-1:0] v;
  logic [31:0] len;
  logic [BYTE_W-1:0] str_tag;
  logic known;

  always_ff @(posedge clk) begin
    if (rst) begin
      string_as_bin <= 1'b0;
      buffer_as_bin <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRING_AS_BIN: string_as_bin <= cfg_wdata[0];
        REG_BUFFER_AS_BIN: buffer_as_bin <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign tok.ready = !full;
  assign push = tok.valid && !full && known;
  assign v = tok.value;
  // Lengths above 32 bits saturate.
  assign len = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];

  always_comb begin
    unique case (tok.cmd)
      CMD_STRING: as_bin = string_as_bin;
      CMD_BUFFER: as_bin = buffer_as_bin;
      default:    as_bin = 1'b0;
    endcase
    str_tag = as_bin ? TAG_BIN8 : TAG_STR8;
  end

  always_comb begin
    known      = 1'b1;
    job.tag    = TAG_NIL;
    job.data   = v;
    job.nbytes = 4'd0;
    unique case (tok.cmd)
      CMD_NIL:    job.tag = TAG_NIL;
      CMD_FALSE:  job.tag = TAG_FALSE;
      CMD_TRUE:   job.tag = TAG_TRUE;
      CMD_SINT, CMD_UINT: begin
        if (tok.cmd == CMD_SINT && v[63]) begin
          if (&v[63:5]) begin
            job.tag = v[7:0];
          end else if (&v[63:7]) begin
            job.tag = TAG_INT8;  job.data = {v[7:0], 56'd0};  job.nbytes = 4'd1;
          end else if (&v[63:15]) begin
            job.tag = TAG_INT16; job.data = {v[15:0], 48'd0}; job.nbytes = 4'd2;
          end else if (&v[63:31]) begin
            job.tag = TAG_INT32; job.data = {v[31:0], 32'd0}; job.nbytes = 4'd4;
          end else begin
            job.tag = TAG_INT64; job.nbytes = 4'd8;
          end
        end else begin
          if (!(|v[63:7])) begin
            job.tag = v[7:0];
          end else if (!(|v[63:8])) begin
            job.tag = TAG_UINT8;  job.data = {v[7:0], 56'd0};  job.nbytes = 4'd1;
          end else if (!(|v[63:16])) begin
            job.tag = TAG_UINT16; job.data = {v[15:0], 48'd0}; job.nbytes = 4'd2;
          end else if (!(|v[63:32])) begin
            job.tag = TAG_UINT32; job.data = {v[31:0], 32'd0}; job.nbytes = 4'd4;
          end else begin
            job.tag = TAG_UINT64; job.nbytes = 4'd8;
          end
        end
      end
      CMD_DOUBLE: begin
        job.tag = TAG_DOUBLE; job.nbytes = 4'd8;
      end
      CMD_STRING, CMD_BUFFER, CMD_SYMBOL: begin
        // Bin has no inline form, so only str uses fixstr.
        if (!as_bin && !(|len[31:5])) begin
          job.tag = TAG_FIXSTR | {3'd0, len[4:0]};
        end else if (!(|len[31:8])) begin
          job.tag = str_tag;        job.data = {len[7:0], 56'd0};  job.nbytes = 4'd1;
        end else if (!(|len[31:16])) begin
          job.tag = str_tag + 8'd1; job.data = {len[15:0], 48'd0}; job.nbytes = 4'd2;
        end else begin
          job.tag = str_tag + 8'd2; job.data = {len, 32'd0};       job.nbytes = 4'd4;
        end
      end
      CMD_ARRAY, CMD_MAP: begin
        if (!(|len[31:4])) begin
          job.tag = ((tok.cmd == CMD_ARRAY) ? TAG_FIXARRAY : TAG_FIXMAP) | {4'd0, len[3:0]};
        end else if (!(|len[31:16])) begin
          job.tag = (tok.cmd == CMD_ARRAY) ? TAG_ARRAY16 : TAG_MAP16;
          job.data = {len[15:0], 48'd0}; job.nbytes = 4'd2;
        end else begin
          job.tag = ((tok.cmd == CMD_ARRAY) ? TAG_ARRAY16 : TAG_MAP16) + 8'd1;
          job.data = {len, 32'd0}; job.nbytes = 4'd4;
        end
      end
      default: known = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/mhe_fifo.sv
`default_nettype none
module mhe_fifo import mhe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  input  wire logic pop,
  output job_t      rdata,
  output logic      full,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t entries [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: src/mhe_back.sv
`default_nettype none
module mhe_back import mhe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic empty,
  output logic      pop,
  mhe_byte_if.source hdr
);

  logic               busy;
  logic [CNT_W-1:0]   rem;
  logic [VALUE_W-1:0] sh;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic               adv;

  assign hdr.valid    = out_valid;
  assign hdr.out_byte = out_byte;
  assign hdr.last     = out_last;

  // The output register can take a new byte when it is empty or being drained.
  assign adv = !out_valid || hdr.ready;
  assign pop = adv && !busy && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (busy) begin
        out_valid <= 1'b1;
        busy      <= (rem != 4'd1);
      end else if (!empty) begin
        out_valid <= 1'b1;
        busy      <= (job.nbytes != 4'd0);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy) begin
        out_byte <= sh[VALUE_W-1 -: BYTE_W];
        out_last <= (rem == 4'd1);
        sh       <= sh << BYTE_W;
        rem      <= rem - 4'd1;
      end else if (!empty) begin
        out_byte <= job.tag;
        out_last <= (job.nbytes == 4'd0);
        sh       <= job.data;
        rem      <= job.nbytes;
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |-> !busy)
    else $error("new token taken while one is still being sent");
  a_busy_rem: assert property (@(posedge clk) disable iff (rst) busy |-> rem != 4'd0)
    else $error("serializer busy with no bytes left");
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> busy)
    else $error("non-final byte shown with nothing left to follow it");

endmodule
`default_nettype wire

FILE: src/msgpack_header_encoder_core.sv
`default_nettype none
// MessagePack header encoder. Each token accepted on tok (nil, booleans, signed
// or unsigned integers, double bit patterns, string, buffer and symbol lengths,
// array and map counts) comes out on hdr as its header bytes, most significant
// first, with last set on the final byte; the smallest form is always chosen.
// A token's header is its tag byte and then the payload bytes of its form
// (0, 1, 2, 4 or 8 of them), sent one at a time through the single byte-wide
// output register, which holds each byte while hdr is not ready. Tokens are
// classified in the cycle they are accepted and wait in a DEPTH-entry queue,
// so tok takes one token a cycle while the queue has room. Unknown commands
// are accepted and produce nothing. Registers: index 0 string_as_bin (reset 0),
// index 1 buffer_as_bin (reset 1); only bit 0 of the write data is kept.
module msgpack_header_encoder_core import mhe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mhe_tok_if.sink                    tok,
  mhe_byte_if.source                 hdr,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  mhe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .full      (full),
    .push      (push),
    .job       (push_job)
  );

  mhe_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (head_job),
    .full  (full),
    .empty (empty)
  );

  mhe_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (head_job),
    .empty (empty),
    .pop   (pop),
    .hdr   (hdr)
  );

endmodule
`default_nettype wire
